### rtl/pet_pkg.sv
// Package with the item, entry and code types shared by the periodic event table.
`default_nettype none
package pet_pkg;

    // At most this many due entries are reported by one check.
    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_CLEAR_MOD = 2'd2,
        OP_CHECK     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DUE   = 2'd0,
        STAT_ADDED = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [15:0]        owner_id;
        logic               switch_state;
        logic [63:0]        start_time;
        logic [31:0]        period;
        logic signed [31:0] repeat_count;
        logic [63:0]        now;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [15:0]        due_module;
        logic               due_switch;
        logic [63:0]        due_time;
        logic [31:0]        due_period;
        logic signed [31:0] due_count;
        logic               last;
    } t_out_item;

    // One stored table entry as it sits in the entry memory.
    typedef struct packed {
        logic [15:0] owner_id;
        logic        switch_state;
        logic [63:0] due_time;
        logic [31:0] period;
        logic [31:0] remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

### rtl/periodic_event_table.sv
// Top level of the periodic event table: entry memory and its sequencer.
//
// The periodic event table keeps an ordered list of up to MAX_ENTRIES scheduled
// events in a single entry memory with a registered read. An add item appends
// an entry and answers with one result item (entry added or table full) in the
// cycle after it is accepted. A clear-all item empties the table and gives no
// result. A clear-module item and a check item with a nonzero time walk the
// table: one entry is read, updated and written back to its compacted position
// every cycle unless a stalled output holds the walk, and after the last entry
// a flush step hands over the final result. The single memory read port is
// used once per entry. Due entries leave in table order; the newest is held in
// a staging register until the walk knows whether another one follows, so the
// last result of a check carries last set. A check reports at most sixteen due
// entries, and later due entries stay for a later check. The block accepts a
// new item only when idle and when its output register is free or being
// emptied. Stored entries have no reset value; only entries below the fill
// count are ever used.
`default_nettype none
module periodic_event_table #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pet_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pet_pkg::t_out_item      o_out_item
);

    import pet_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // All entry fields live side by side in one memory word.
    pet_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The sequencer reads ahead of its write pointer, so a walk never reads an
    // entry that a pending write still has to update.
    pet_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

### rtl/pet_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/pet_ctrl.sv
// Sequencer for the event table: operation decode, table walk with compaction, result staging.
`default_nettype none
module pet_ctrl #(
    parameter int MAX_ENTRIES = 16,
    parameter int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire pet_pkg::t_in_item        i_in_item,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output pet_pkg::t_out_item            o_out_item,
    output logic                          o_ram_we,
    output logic [IW-1:0]                 o_ram_waddr,
    output logic [pet_pkg::ENTRY_W-1:0]   o_ram_wdata,
    output logic [IW-1:0]                 o_ram_raddr,
    input  wire logic [pet_pkg::ENTRY_W-1:0] i_ram_rdata
);

    import pet_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_wr;
    logic [RES_CNT_W-1:0]   r_n;
    t_op                    r_op;
    logic [15:0]            r_mod;
    logic [63:0]            r_now;
    t_out_item              r_pend;
    logic                   r_pend_v;
    t_out_item              r_out;
    logic                   r_out_v;

    t_entry                 cur;
    t_entry                 upd;
    t_entry                 add_entry;
    t_out_item              due_item;
    t_out_item              add_item;
    t_out_item              out_data;
    logic [31:0]            c_dec;
    logic [CW-1:0]          idx_inc;
    logic                   accept;
    logic                   out_free;
    logic                   hit_due;
    logic                   keep;
    logic                   walk_stall;
    logic                   walk_last;
    logic                   table_full;
    logic                   load_out;
    logic                   load_pend;
    logic                   clear_pend;
    logic                   advance;

    // Entry datapath: decide what the entry under the walk becomes.
    always_comb begin
        cur        = t_entry'(i_ram_rdata);
        idx_inc    = r_idx + CW'(1);
        out_free   = !r_out_v || i_out_ready;
        accept     = i_in_valid && (r_state == ST_IDLE) && out_free;
        table_full = (r_count >= CW'(MAX_ENTRIES));
        walk_last  = (idx_inc == r_count);

        hit_due = (r_op == OP_CHECK) && (cur.due_time <= r_now)
                  && (r_n < RES_CNT_W'(RESULT_LIMIT));
        // Negative counts repeat forever and zero fires once, so neither is decremented.
        c_dec = ((cur.remaining != 32'd0) && !cur.remaining[31])
                ? cur.remaining - 32'd1 : cur.remaining;
        if (r_op == OP_CHECK) begin
            keep = !hit_due || (c_dec != 32'd0);
        end else begin
            keep = (cur.owner_id != r_mod);
        end

        upd = cur;
        if (hit_due) begin
            upd.remaining = c_dec;
            upd.due_time  = r_now + {32'd0, cur.period};
        end

        due_item.status     = STAT_DUE;
        due_item.due_module = cur.owner_id;
        due_item.due_switch = cur.switch_state;
        due_item.due_time   = cur.due_time;
        due_item.due_period = cur.period;
        due_item.due_count  = $signed(cur.remaining);
        due_item.last       = 1'b0;

        add_entry.owner_id     = i_in_item.owner_id;
        add_entry.switch_state = i_in_item.switch_state;
        add_entry.due_time     = i_in_item.start_time;
        add_entry.period       = i_in_item.period;
        add_entry.remaining    = unsigned'(i_in_item.repeat_count);

        add_item.status     = table_full ? STAT_FULL : STAT_ADDED;
        add_item.due_module = i_in_item.owner_id;
        add_item.due_switch = i_in_item.switch_state;
        add_item.due_time   = i_in_item.start_time;
        add_item.due_period = i_in_item.period;
        add_item.due_count  = i_in_item.repeat_count;
        add_item.last       = 1'b1;

        // A new due entry can only displace the staged one if the output register has room.
        walk_stall = hit_due && r_pend_v && !out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_item.operation)
                        OP_CLEAR_MOD: begin
                            if (r_count != '0) n_state = ST_WALK;
                        end
                        OP_CHECK: begin
                            if ((i_in_item.now != 64'd0) && (r_count != '0)) begin
                                n_state = ST_WALK;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (!walk_stall && walk_last) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_pend_v || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wr[IW-1:0];
        o_ram_wdata = ENTRY_W'(upd);
        o_ram_raddr = '0;
        load_out    = 1'b0;
        out_data    = r_pend;
        load_pend   = 1'b0;
        clear_pend  = 1'b0;
        advance     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = out_free;
                o_ram_raddr = '0;
                if (accept && (i_in_item.operation == OP_ADD)) begin
                    o_ram_we    = !table_full;
                    o_ram_waddr = r_count[IW-1:0];
                    o_ram_wdata = ENTRY_W'(add_entry);
                    load_out    = 1'b1;
                    out_data    = add_item;
                end
            end
            ST_WALK: begin
                o_ram_raddr = walk_stall ? r_idx[IW-1:0] : idx_inc[IW-1:0];
                if (!walk_stall) begin
                    advance  = 1'b1;
                    o_ram_we = keep;
                    if (hit_due) begin
                        load_pend = 1'b1;
                        load_out  = r_pend_v;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_pend_v && out_free) begin
                    load_out      = 1'b1;
                    out_data.last = 1'b1;
                    clear_pend    = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                r_op  <= i_in_item.operation;
                r_mod <= i_in_item.owner_id;
                r_now <= i_in_item.now;
                r_idx <= '0;
                r_wr  <= '0;
                r_n   <= '0;
                if (i_in_item.operation == OP_ADD && !table_full) begin
                    r_count <= r_count + CW'(1);
                end else if (i_in_item.operation == OP_CLEAR) begin
                    r_count <= '0;
                end
            end

            if (advance) begin
                r_idx <= idx_inc;
                if (keep) r_wr <= r_wr + CW'(1);
                if (hit_due) r_n <= r_n + RES_CNT_W'(1);
                if (walk_last) r_count <= keep ? r_wr + CW'(1) : r_wr;
            end

            if (load_out) begin
                r_out   <= out_data;
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end

            if (load_pend) begin
                r_pend   <= due_item;
                r_pend_v <= 1'b1;
            end else if (clear_pend) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire
